// ===== rtl/rlp_pkg.sv =====
// Shared types and constants for the rlp item decoder.
// No dependencies; imported by rlp_item_decoder.
`default_nettype none

package rlp_pkg;

    // result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_VALUE   = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_SINGLE   = 3'd1;
    localparam logic [2:0] ERR_SIZE     = 3'd2;
    localparam logic [2:0] ERR_LEAD     = 3'd3;
    localparam logic [2:0] ERR_LIST     = 3'd4;
    localparam logic [2:0] ERR_OVERFLOW = 3'd5;

    // decode modes
    localparam logic [1:0] MODE_HEADER = 2'd0;
    localparam logic [1:0] MODE_STRING = 2'd1;
    localparam logic [1:0] MODE_VALUE  = 2'd2;

    // register indexes
    localparam logic REG_MODE = 1'b0;

    // phases
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_CHECK1  = 3'd1;
    localparam logic [2:0] PH_LENGTH  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_VALUE   = 3'd4;

    // prefix boundaries
    localparam logic [7:0] PFX_STRING      = 8'h80;
    localparam logic [7:0] PFX_ONE_BYTE    = 8'h81;
    localparam logic [7:0] PFX_LONG_STRING = 8'hB8;
    localparam logic [7:0] PFX_LIST        = 8'hC0;
    localparam logic [7:0] PFX_LONG_LIST   = 8'hF8;
    localparam logic [7:0] BASE_LONG_STR   = 8'hB7;
    localparam logic [7:0] BASE_LONG_LIST  = 8'hF7;
    localparam logic [63:0] MIN_LONG_LEN   = 64'd56;
    localparam logic [63:0] MAX_VALUE_LEN  = 64'd8;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic        is_list;
        logic [63:0] item_length;
        logic [63:0] data;
        logic [2:0]  error_code;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [3:0]  len_left;
        logic [63:0] len_acc;
        logic [63:0] pay_left;
        logic [63:0] val_acc;
        logic        list_flag;
    } st_t;

    function automatic res_t mk_res(logic [1:0] kind, logic lst, logic [63:0] len,
                                    logic [63:0] dat, logic [2:0] err, logic lst_mark);
        res_t r;
        r.kind        = kind;
        r.is_list     = lst;
        r.item_length = len;
        r.data        = dat;
        r.error_code  = err;
        r.last        = lst_mark;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rlp_item_decoder.sv =====
// RLP item decoder top level: prefix classification, length gathering,
// canonical checks and a small result queue. Depends on rlp_pkg.
`default_nettype none

//  channel   | handshake                  | payload
//  ----------+----------------------------+-------------------------------------
//  input     | in_valid / in_ready        | stream_byte
//  result    | out_valid / out_ready      | kind is_list item_length data
//            |                            | error_code last
//  config    | psel penable pwrite pready | paddr pwdata prdata (mode at 0x0)
//
//  one stream byte is decoded in the cycle it is accepted; its zero, one or two
//  result words go into a four-word result queue, so a byte can be taken every
//  cycle while the queue holds at most two words.
//  a byte that yields a header and a payload word takes two queue slots.
//  in_ready drops while three or more words wait, stalls on out_ready included.
//  reset clears the decoder state, the queue and mode; no clearing pass.

module rlp_item_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  stream_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [1:0]  kind,
    output logic             is_list,
    output logic      [63:0] item_length,
    output logic      [63:0] data,
    output logic      [2:0]  error_code,
    output logic             last
);
    import rlp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [1:0]  mode_reg;
    st_t         st_reg, st_next;
    res_t        queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic        in_acc, out_acc, cfg_wr;
    logic        val_mode, strict_list;
    res_t        r0, r1;
    logic [1:0]  n_res, n_push;
    logic        hdr_go, hdr_list, take_single;
    logic [63:0] hdr_len;
    logic [63:0] acc_shift, val_shift, left_dec;
    logic [3:0]  len_left_dec;
    logic [7:0]  b;

    assign b       = stream_byte;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (paddr[2] == REG_MODE) ? {30'd0, mode_reg} : 32'd0;

    assign in_ready  = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign in_acc    = in_valid && in_ready;
    assign out_valid = (count_reg != '0);
    assign out_acc   = out_valid && out_ready;

    // mode 3 acts as mode 0
    assign val_mode    = (mode_reg == MODE_VALUE);
    assign strict_list = (mode_reg == MODE_STRING) || (mode_reg == MODE_VALUE);

    assign acc_shift    = {st_reg.len_acc[55:0], b};
    assign val_shift    = {st_reg.val_acc[55:0], b};
    assign left_dec     = st_reg.pay_left - 64'd1;
    assign len_left_dec = (st_reg.len_left != 4'd0) ? st_reg.len_left - 4'd1 : 4'd0;

    always_comb
    begin
        st_next     = st_reg;
        r0          = '0;
        r1          = '0;
        n_res       = 2'd0;
        hdr_go      = 1'b0;
        hdr_list    = 1'b0;
        hdr_len     = '0;
        take_single = 1'b0;

        unique case (st_reg.phase)
            PH_IDLE:
            begin
                if (b < PFX_STRING)
                begin
                    take_single = 1'b1;
                end
                else if (b < PFX_LONG_STRING)
                begin
                    if (b == PFX_ONE_BYTE)
                    begin
                        st_next       = '0;
                        st_next.phase = PH_CHECK1;
                    end
                    else
                    begin
                        hdr_go  = 1'b1;
                        hdr_len = {56'd0, b - PFX_STRING};
                    end
                end
                else if (b < PFX_LIST)
                begin
                    st_next           = '0;
                    st_next.phase     = PH_LENGTH;
                    st_next.len_left  = 4'(b - BASE_LONG_STR);
                end
                else if (b < PFX_LONG_LIST)
                begin
                    hdr_go   = 1'b1;
                    hdr_list = 1'b1;
                    hdr_len  = {56'd0, b - PFX_LIST};
                end
                else
                begin
                    st_next           = '0;
                    st_next.phase     = PH_LENGTH;
                    st_next.len_left  = 4'(b - BASE_LONG_LIST);
                    st_next.list_flag = 1'b1;
                end
            end
            PH_CHECK1:
            begin
                if (b < PFX_STRING)
                begin
                    st_next = '0;
                    r0      = mk_res(KIND_ERROR, 1'b0, '0, '0, ERR_SINGLE, 1'b1);
                    n_res   = 2'd1;
                end
                else
                begin
                    take_single = 1'b1;
                end
            end
            PH_LENGTH:
            begin
                if (st_reg.len_acc == '0 && b == 8'd0)
                begin
                    st_next = '0;
                    r0      = mk_res(KIND_ERROR, 1'b0, '0, '0, ERR_LEAD, 1'b1);
                    n_res   = 2'd1;
                end
                else if (len_left_dec == 4'd0)
                begin
                    if (acc_shift < MIN_LONG_LEN)
                    begin
                        st_next = '0;
                        r0      = mk_res(KIND_ERROR, 1'b0, '0, '0, ERR_SIZE, 1'b1);
                        n_res   = 2'd1;
                    end
                    else
                    begin
                        hdr_go   = 1'b1;
                        hdr_len  = acc_shift;
                        hdr_list = st_reg.list_flag;
                    end
                end
                else
                begin
                    st_next.len_acc  = acc_shift;
                    st_next.len_left = len_left_dec;
                end
            end
            PH_PAYLOAD:
            begin
                r0    = mk_res(KIND_PAYLOAD, 1'b0, '0, {56'd0, b}, ERR_NONE,
                               left_dec == '0);
                n_res = 2'd1;
                if (left_dec == '0)
                begin
                    st_next = '0;
                end
                else
                begin
                    st_next.pay_left = left_dec;
                end
            end
            PH_VALUE:
            begin
                if (st_reg.val_acc == '0 && b == 8'd0)
                begin
                    st_next = '0;
                    r0      = mk_res(KIND_ERROR, 1'b0, '0, '0, ERR_LEAD, 1'b1);
                    n_res   = 2'd1;
                end
                else if (left_dec == '0)
                begin
                    st_next = '0;
                    r0      = mk_res(KIND_VALUE, 1'b0, st_reg.len_acc, val_shift,
                                     ERR_NONE, 1'b1);
                    n_res   = 2'd1;
                end
                else
                begin
                    st_next.val_acc  = val_shift;
                    st_next.pay_left = left_dec;
                end
            end
            default:
            begin
                st_next = '0;
            end
        endcase

        // complete header: act on it by mode
        if (hdr_go)
        begin
            st_next = '0;
            n_res   = 2'd1;
            if (hdr_list)
            begin
                if (strict_list)
                    r0 = mk_res(KIND_ERROR, 1'b0, '0, '0, ERR_LIST, 1'b1);
                else
                    r0 = mk_res(KIND_HEADER, 1'b1, hdr_len, '0, ERR_NONE, 1'b1);
            end
            else if (val_mode)
            begin
                if (hdr_len > MAX_VALUE_LEN)
                begin
                    r0 = mk_res(KIND_ERROR, 1'b0, '0, '0, ERR_OVERFLOW, 1'b1);
                end
                else if (hdr_len == '0)
                begin
                    r0 = mk_res(KIND_VALUE, 1'b0, '0, '0, ERR_NONE, 1'b1);
                end
                else
                begin
                    n_res            = 2'd0;
                    st_next.phase    = PH_VALUE;
                    st_next.pay_left = hdr_len;
                    st_next.len_acc  = hdr_len;
                end
            end
            else
            begin
                r0 = mk_res(KIND_HEADER, 1'b0, hdr_len, '0, ERR_NONE, hdr_len == '0);
                if (hdr_len != '0)
                begin
                    st_next.phase    = PH_PAYLOAD;
                    st_next.pay_left = hdr_len;
                end
            end
        end

        // lone byte as a one-byte item
        if (take_single)
        begin
            st_next = '0;
            n_res   = 2'd1;
            if (val_mode)
            begin
                if (b == 8'd0)
                    r0 = mk_res(KIND_ERROR, 1'b0, '0, '0, ERR_LEAD, 1'b1);
                else
                    r0 = mk_res(KIND_VALUE, 1'b0, 64'd1, {56'd0, b}, ERR_NONE, 1'b1);
            end
            else
            begin
                r0    = mk_res(KIND_HEADER, 1'b0, 64'd1, '0, ERR_NONE, 1'b0);
                r1    = mk_res(KIND_PAYLOAD, 1'b0, '0, {56'd0, b}, ERR_NONE, 1'b1);
                n_res = 2'd2;
            end
        end
    end

    assign n_push = in_acc ? n_res : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_HEADER;
            st_reg     <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (cfg_wr && paddr[2] == REG_MODE)
                mode_reg <= pwdata[1:0];
            if (in_acc)
                st_reg <= st_next;
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_push);
            if (out_acc)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_reg + CNT_W'(n_push) - CNT_W'(out_acc);
        end
    end

    // result words, no reset needed
    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            queue_reg[wr_ptr_reg] <= r0;
        if (n_push == 2'd2)
            queue_reg[wr_ptr_reg + PTR_W'(1)] <= r1;
    end

    assign kind        = queue_reg[rd_ptr_reg].kind;
    assign is_list     = queue_reg[rd_ptr_reg].is_list;
    assign item_length = queue_reg[rd_ptr_reg].item_length;
    assign data        = queue_reg[rd_ptr_reg].data;
    assign error_code  = queue_reg[rd_ptr_reg].error_code;
    assign last        = queue_reg[rd_ptr_reg].last;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_length_left: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.phase == PH_LENGTH) |-> (st_reg.len_left != 4'd0 && st_reg.len_left <= 4'd8))
        else $error("length byte count out of range");

    a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.phase == PH_PAYLOAD || st_reg.phase == PH_VALUE) |-> st_reg.pay_left != '0)
        else $error("payload phase with nothing left");

    a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_ERROR) |-> (last && error_code != ERR_NONE))
        else $error("error word without code or last mark");

endmodule

`default_nettype wire

// ===== tb/sv/rlp_item_decoder_tb.sv =====
// Self-checking testbench for rlp_item_decoder: random RLP byte streams in every mode,
// results checked word by word against a behavioral decoder held in a scoreboard class.
// Depends on rlp_pkg and rlp_item_decoder.
`timescale 1ns / 1ps

module rlp_item_decoder_tb;

    import rlp_pkg::*;

    // mode 3 decodes like header mode
    localparam logic [1:0] MODE_ALIAS = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned LONG_HOLD_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES = 8;

    class rlp_scoreboard;
        logic [1:0]  mode;
        logic [2:0]  phase;
        logic [3:0]  len_left;
        logic [63:0] len_acc;
        logic [63:0] pay_left;
        logic [63:0] val_acc;
        logic        list_flag;
        res_t        pending_words[$];
        int unsigned fails;

        function new();
            mode = MODE_HEADER;
            fails = 0;
            go_idle();
        endfunction

        function void go_idle();
            phase = PH_IDLE;
            len_left = '0;
            len_acc = '0;
            pay_left = '0;
            val_acc = '0;
            list_flag = 1'b0;
        endfunction

        function logic [1:0] eff_mode();
            return (mode == MODE_ALIAS) ? MODE_HEADER : mode;
        endfunction

        function void post(logic [1:0] k, logic lst, logic [63:0] len, logic [63:0] dat,
                           logic [2:0] err, logic fin);
            res_t w;
            w.kind = k;
            w.is_list = lst;
            w.item_length = len;
            w.data = dat;
            w.error_code = err;
            w.last = fin;
            pending_words.push_back(w);
        endfunction

        function void reject(logic [2:0] err);
            post(KIND_ERROR, 1'b0, 64'd0, 64'd0, err, 1'b1);
            go_idle();
        endfunction

        function void take_header(logic [63:0] len, logic lst);
            if (lst) begin
                if (eff_mode() != MODE_HEADER)
                    reject(ERR_LIST);
                else
                begin
                    post(KIND_HEADER, 1'b1, len, 64'd0, ERR_NONE, 1'b1);
                    go_idle();
                end
                return;
            end
            if (eff_mode() == MODE_VALUE) begin
                if (len > MAX_VALUE_LEN)
                    reject(ERR_OVERFLOW);
                else if (len == 64'd0)
                begin
                    post(KIND_VALUE, 1'b0, 64'd0, 64'd0, ERR_NONE, 1'b1);
                    go_idle();
                end
                else
                begin
                    go_idle();
                    phase = PH_VALUE;
                    pay_left = len;
                    len_acc = len;
                end
                return;
            end
            post(KIND_HEADER, 1'b0, len, 64'd0, ERR_NONE, len == 64'd0);
            go_idle();
            if (len != 64'd0) begin
                phase = PH_PAYLOAD;
                pay_left = len;
            end
        endfunction

        function void take_body(logic [7:0] b);
            if (phase == PH_PAYLOAD) begin
                pay_left = pay_left - 64'd1;
                post(KIND_PAYLOAD, 1'b0, 64'd0, {56'd0, b}, ERR_NONE, pay_left == 64'd0);
                if (pay_left == 64'd0)
                    go_idle();
            end
            else if (phase == PH_VALUE)
            begin
                if (val_acc == 64'd0 && b == 8'h00) begin
                    reject(ERR_LEAD);
                    return;
                end
                val_acc = (val_acc << 8) | {56'd0, b};
                pay_left = pay_left - 64'd1;
                if (pay_left == 64'd0) begin
                    post(KIND_VALUE, 1'b0, len_acc, val_acc, ERR_NONE, 1'b1);
                    go_idle();
                end
            end
        endfunction

        function void start_length(logic [7:0] count, logic lst);
            go_idle();
            phase = PH_LENGTH;
            len_left = count[3:0];
            list_flag = lst;
        endfunction

        // advance the decoder by one accepted stream byte
        function void note_byte(logic [7:0] b);
            logic [63:0] wide;
            wide = {56'd0, b};
            case (phase)
                PH_IDLE:
                begin
                    if (b < PFX_STRING) begin
                        take_header(64'd1, 1'b0);
                        take_body(b);
                    end
                    else if (b < PFX_LONG_STRING)
                    begin
                        if (b == PFX_ONE_BYTE) begin
                            go_idle();
                            phase = PH_CHECK1;
                        end
                        else
                            take_header(wide - {56'd0, PFX_STRING}, 1'b0);
                    end
                    else if (b < PFX_LIST)
                        start_length(b - BASE_LONG_STR, 1'b0);
                    else if (b < PFX_LONG_LIST)
                        take_header(wide - {56'd0, PFX_LIST}, 1'b1);
                    else
                        start_length(b - BASE_LONG_LIST, 1'b1);
                end
                PH_CHECK1:
                begin
                    if (b < PFX_STRING)
                        reject(ERR_SINGLE);
                    else
                    begin
                        take_header(64'd1, 1'b0);
                        take_body(b);
                    end
                end
                PH_LENGTH:
                begin
                    if (len_acc == 64'd0 && b == 8'h00)
                        reject(ERR_LEAD);
                    else
                    begin
                        len_acc = (len_acc << 8) | wide;
                        if (len_left != 4'd0)
                            len_left = len_left - 4'd1;
                        if (len_left == 4'd0) begin
                            if (len_acc < MIN_LONG_LEN)
                                reject(ERR_SIZE);
                            else
                                take_header(len_acc, list_flag);
                        end
                    end
                end
                PH_PAYLOAD, PH_VALUE:
                    take_body(b);
                default:
                    go_idle();
            endcase
        endfunction

        function void check_word(res_t got);
            res_t want;
            if (pending_words.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("unexpected word: kind=%0d list=%0d len=%h data=%h err=%0d last=%0d",
                             got.kind, got.is_list, got.item_length, got.data,
                             got.error_code, got.last);
                return;
            end
            want = pending_words.pop_front();
            if (got.kind !== want.kind || got.is_list !== want.is_list ||
                got.item_length !== want.item_length || got.data !== want.data ||
                got.error_code !== want.error_code || got.last !== want.last) begin
                fails++;
                if (fails <= 10)
                    $display("word mismatch: exp kind=%0d list=%0d len=%h data=%h err=%0d last=%0d",
                             want.kind, want.is_list, want.item_length, want.data,
                             want.error_code, want.last,
                             "\n               got kind=%0d list=%0d len=%h data=%h err=%0d last=%0d",
                             got.kind, got.is_list, got.item_length, got.data,
                             got.error_code, got.last);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  stream_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic        is_list;
    logic [63:0] item_length;
    logic [63:0] data;
    logic [2:0]  error_code;
    logic        last;

    rlp_scoreboard sb;
    rlp_scoreboard plan;     // tracks decoder state while the stream is built
    logic [7:0]    stim_bytes[$];
    logic          idle_on = 1'b1;
    logic          long_hold = 1'b0;
    int unsigned   cycles = 0;

    rlp_item_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .stream_byte (stream_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .is_list     (is_list),
        .item_length (item_length),
        .data        (data),
        .error_code  (error_code),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------- stream construction ----------------

    function automatic void queue_byte(logic [7:0] b);
        plan.note_byte(b);
        plan.pending_words.delete();
        stim_bytes.push_back(b);
    endfunction

    // random byte, except that a long string length never runs past one byte,
    // so a random prefix cannot open a payload that never ends
    function automatic logic [7:0] noise_byte();
        if (plan.phase == PH_LENGTH && !plan.list_flag && plan.eff_mode() != MODE_VALUE &&
            plan.len_left > 4'd1)
            return 8'h00;
        return 8'($urandom);
    endfunction

    function automatic void settle();
        while (plan.phase != PH_IDLE)
            queue_byte(noise_byte());
    endfunction

    function automatic void encode_header(ref logic [7:0] q[$], input logic [63:0] len,
                                          input logic lst);
        int nb;
        int k;
        if (len < MIN_LONG_LEN) begin
            q.push_back((lst ? PFX_LIST : PFX_STRING) + len[7:0]);
            return;
        end
        nb = 0;
        for (k = 0; k < 8; k++)
            if (len[8*k +: 8] != 8'h00)
                nb = k + 1;
        q.push_back((lst ? BASE_LONG_LIST : BASE_LONG_STR) + 8'(nb));
        for (k = nb - 1; k >= 0; k--)
            q.push_back(len[8*k +: 8]);
    endfunction

    function automatic void encode_string(ref logic [7:0] q[$], input int unsigned n);
        logic [7:0]  first;
        int unsigned k;
        first = 8'($urandom);
        if (n == 1 && first < PFX_STRING) begin
            q.push_back(first);
            return;
        end
        encode_header(q, 64'(n), 1'b0);
        for (k = 0; k < n; k++)
            q.push_back(k == 0 ? first : 8'($urandom));
    endfunction

    // canonical unsigned value of 0 to 8 bytes
    function automatic void encode_value(ref logic [7:0] q[$]);
        int          nb;
        int          k;
        logic [63:0] v;
        nb = $urandom_range(0, 8);
        v = {$urandom, $urandom};
        if (nb == 0) begin
            q.push_back(PFX_STRING);
            return;
        end
        if (v[8*(nb-1) +: 8] == 8'h00)
            v[8*(nb-1) +: 8] = 8'h01;
        if (nb == 1 && v[7:0] < PFX_STRING) begin
            q.push_back(v[7:0]);
            return;
        end
        q.push_back(PFX_STRING + 8'(nb));
        for (k = nb - 1; k >= 0; k--)
            q.push_back(v[8*k +: 8]);
    endfunction

    function automatic void encode_list(ref logic [7:0] q[$], input int depth);
        logic [7:0]  body[$];
        logic [63:0] len;
        int          nb;
        int          n;
        // header only, with a wide length that no content follows
        if (depth > 1 || $urandom_range(0, 3) == 0) begin
            nb = $urandom_range(1, 8);
            len = {$urandom, $urandom};
            if (nb < 8)
                len = len & ((64'd1 << (8 * nb)) - 64'd1);
            if (len < MIN_LONG_LEN)
                len = len | MIN_LONG_LEN;
            encode_header(q, len, 1'b1);
            return;
        end
        n = $urandom_range(0, 3);
        repeat (n)
            case ($urandom_range(0, 2))
                0:       encode_string(body, $urandom_range(0, 6));
                1:       encode_value(body);
                default: encode_list(body, depth + 1);
            endcase
        encode_header(q, 64'(body.size()), 1'b1);
        foreach (body[k])
            q.push_back(body[k]);
    endfunction

    function automatic int unsigned pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(0, 8);
        if (r < 85)
            return $urandom_range(9, 55);
        if (r < 97)
            return $urandom_range(56, 80);
        return $urandom_range(256, 270);
    endfunction

    function automatic void queue_random_item();
        logic [7:0]  item_q[$];
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            repeat ($urandom_range(1, 4))
                queue_byte(noise_byte());
            return;
        end
        settle();
        if (plan.eff_mode() == MODE_VALUE) begin
            if (pick < 70)
                encode_value(item_q);
            else if (pick < 88)
                encode_string(item_q, $urandom_range(0, 12));
            else
                encode_list(item_q, 0);
        end
        else
        begin
            if (pick < 60)
                encode_string(item_q, pick_length());
            else if (pick < 70)
                encode_value(item_q);
            else
                encode_list(item_q, 0);
        end
        foreach (item_q[k])
            queue_byte(item_q[k]);
    endfunction

    function automatic void queue_directed(logic [1:0] m);
        logic [7:0] d[$];
        case (m)
            MODE_HEADER:
            begin
                // singles, empty string, wrapped singles, short and long lists,
                // size and leading zero errors, widest list length
                d = '{8'h00, 8'h7F, PFX_STRING, PFX_ONE_BYTE, 8'h80, PFX_ONE_BYTE, 8'h7F,
                      8'h82, 8'hAA, 8'h55, PFX_LIST, 8'hF7, 8'hB8, 8'h37, 8'hB9, 8'h00,
                      8'hF8, 8'h38, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                      8'hFF, 8'hFF};
                encode_string(d, 56);
            end
            MODE_STRING:
            begin
                d = '{8'hC1, 8'h00, 8'hF8, 8'h40, 8'h83, 8'h01, 8'h02, 8'h03};
                encode_string(d, 60);
            end
            MODE_VALUE:
            begin
                // zero single, value zero, widest value, overflow short and long,
                // leading zero, list, size error, wrapped singles, long list
                d = '{8'h00, 8'h01, 8'h7F, PFX_STRING, 8'h88, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h89, 8'h82, 8'h00, 8'h01, PFX_LIST,
                      8'hB8, 8'h40, 8'hB8, 8'h05, PFX_ONE_BYTE, 8'h05, PFX_ONE_BYTE, 8'h80,
                      8'hF9, 8'h01, 8'h00};
            end
            default:
                d = '{8'h05, 8'hC2, PFX_STRING};
        endcase
        foreach (d[k])
            queue_byte(d[k]);
        settle();
    endfunction

    // ---------------- drivers ----------------

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_stream();
        logic [7:0] b;
        while (stim_bytes.size() > 0) begin
            if (idle_on && $urandom_range(0, 5) == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 14))
                    @(posedge clk);
            end
            b = stim_bytes.pop_front();
            in_valid <= 1'b1;
            stream_byte <= b;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            sb.note_byte(b);
        end
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending_words.size() != 0)
            @(posedge clk);
        // a trailing byte may still be in flight without a word
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // result side: check accepted words, idle in bursts, one long hold on request
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_word(res_t'({kind, is_list, item_length, data, error_code, last}));
            if (stall_left == 0 && long_hold) begin
                long_hold = 1'b0;
                stall_left = LONG_HOLD_CYCLES;
            end
            else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 14);
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        logic [1:0]  modes[5];
        int unsigned targets[5];
        int unsigned start_size;
        int          p;
        modes = '{MODE_HEADER, MODE_STRING, MODE_VALUE, MODE_ALIAS, MODE_HEADER};
        // random bytes per mode; directed bytes and settling come on top
        targets = '{90, 70, 90, 50, 90};
        sb = new();
        plan = new();
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (p = 0; p < 5; p++) begin
            idle_on = (p != 4);
            write_reg({REG_MODE, 2'b00}, {30'd0, modes[p]});
            sb.mode = modes[p];
            plan.mode = modes[p];
            stim_bytes.delete();
            if (p < 4)
                queue_directed(modes[p]);
            start_size = stim_bytes.size();
            while (stim_bytes.size() - start_size < targets[p])
                queue_random_item();
            settle();
            if (p == 0 || p == 2)
                long_hold = 1'b1;
            send_stream();
            drain();
        end
        repeat (20)
            @(posedge clk);
        if (sb.fails == 0 && sb.pending_words.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
